### src/gsl_pkg.sv
// Shared types, constants and grid mapping for the shadowcasting light map.
package gsl_pkg;

    localparam int MAP_SIZE = 64;
    localparam int MAP_CW = $clog2(MAP_SIZE);
    localparam int MAP_AW = 2 * MAP_CW;
    localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;

    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W = STACK_AW + 1;

    localparam int MODE_W = 2;
    localparam int CELL_W = 6;
    localparam int KIND_W = 3;
    localparam int RAD_W = 8;

    localparam int CW = MAP_CW + 4;
    localparam int OPW = CW + 2;
    localparam int PW = 2 * OPW;
    localparam int DW = 2 * CW - 2;
    localparam int FR_FW = 8;
    localparam int FRAME_W = 5 * FR_FW;

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHINE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

    localparam logic [KIND_W-1:0] TILE_WALL = 3'd4;
    localparam logic [KIND_W-1:0] TILE_DOOR_CLOSED = 3'd5;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [OPW-1:0] t_op;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        logic [FR_FW-1:0] x;
        logic [FR_FW-1:0] ty;
        logic [FR_FW-1:0] tx;
        logic [FR_FW-1:0] by;
        logic [FR_FW-1:0] bx;
    } t_frame;

    typedef struct packed {
        logic off;
        logic [MAP_AW-1:0] addr;
    } t_gpos;

    function automatic t_gpos grid_addr(t_coord cx, t_coord cy);
        t_gpos p;
        p.off = (cx < t_coord'(0)) || (cy < t_coord'(0)) ||
                (cx >= t_coord'(MAP_SIZE)) || (cy >= t_coord'(MAP_SIZE));
        p.addr = {cy[MAP_CW-1:0], cx[MAP_CW-1:0]};
        return p;
    endfunction

    function automatic t_gpos to_grid(logic [2:0] oct, t_coord ox, t_coord oy,
                                      t_coord x, t_coord y);
        t_coord dx;
        t_coord dy;
        unique case (oct)
            3'd0: begin dx = x;  dy = -y; end
            3'd1: begin dx = y;  dy = -x; end
            3'd2: begin dx = -y; dy = -x; end
            3'd3: begin dx = -x; dy = -y; end
            3'd4: begin dx = -x; dy = y;  end
            3'd5: begin dx = -y; dy = x;  end
            3'd6: begin dx = y;  dy = x;  end
            default: begin dx = x; dy = y; end
        endcase
        return grid_addr(ox + dx, oy + dy);
    endfunction

endpackage

### src/gsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/grid_shadowcast_light_map_core.sv
// Top level of the shadowcasting light map: sequencer, maps, frame stack and arithmetic.
// A tile load is answered from the idle state, a lit read after the registered lit-map read, and
// a clear of the lit map writes each of its 4096 cells (a 64 by 64 grid); after reset the block
// clears both maps before it accepts its first transaction. A light run is walked by one
// sequencer over the eight octants: each visited cell uses the shared pair of multipliers and
// the opacity memory port, and each column edge whose slope is not trivial adds a bit-serial
// division, so the length of a run depends on radius and walls.
// Each result waits in an output register until taken, and the next transaction is
// accepted once it has gone.
module grid_shadowcast_light_map_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [gsl_pkg::MODE_W-1:0]        i_mode,
    input  logic [gsl_pkg::CELL_W-1:0]        i_cell_x,
    input  logic [gsl_pkg::CELL_W-1:0]        i_cell_y,
    input  logic [gsl_pkg::KIND_W-1:0]        i_tile_kind,
    input  logic signed [gsl_pkg::RAD_W-1:0]  i_radius,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_lit_bit,
    output logic                              o_stack_overflow
);

    typedef enum logic [5:0] {
        S_RST_CLR, S_IDLE, S_RD, S_CLR, S_SH0, S_COL, S_TDIV, S_DIV, S_TQ,
        S_TB0, S_TB1, S_TB2, S_TB3, S_TB4, S_TB5, S_BOT, S_BDIV, S_BQ,
        S_BB0, S_BB1, S_BB2, S_CINIT, S_C0, S_C1, S_C2, S_C3,
        S_OPN0, S_OPN1, S_OPN2, S_TRN0, S_TRN1, S_TRN2, S_CEND,
        S_POP, S_POPW, S_DONE
    } t_state;

    localparam logic [1:0] WAS_NONE = 2'd0;
    localparam logic [1:0] WAS_OPEN = 2'd1;
    localparam logic [1:0] WAS_OPAQ = 2'd2;

    localparam gsl_pkg::t_coord K0 = gsl_pkg::t_coord'(0);
    localparam gsl_pkg::t_coord K1 = gsl_pkg::t_coord'(1);
    localparam gsl_pkg::t_op O1 = gsl_pkg::t_op'(1);
    localparam gsl_pkg::t_op O0 = gsl_pkg::t_op'(0);
    localparam int DCNT_W = $clog2(gsl_pkg::DW);

    t_state r_state;
    logic [gsl_pkg::MAP_AW-1:0] r_clr;
    logic r_ovalid, r_lit, r_ovf, r_in_off, r_off, r_unl, r_op, r_ctop, r_dbot;
    logic signed [gsl_pkg::RAD_W-1:0] r_range;
    logic [2:0] r_oct;
    logic [gsl_pkg::SP_W-1:0] r_sp;
    logic [1:0] r_was;
    gsl_pkg::t_coord r_org_x, r_org_y, r_x, r_y, r_top, r_bot;
    gsl_pkg::t_coord r_ty, r_tx, r_by, r_bx, r_nx, r_ny, r_ax;
    gsl_pkg::t_prod r_pl, r_pr, r_reach2;
    logic [gsl_pkg::DW-1:0] r_num, r_rem, r_den;
    logic [DCNT_W-1:0] r_dcnt;

    logic in_acc, blk, opq_rd, lit_rd;
    logic opq_we, opq_wd, lit_we, lit_wd, stk_we;
    logic [gsl_pkg::MAP_AW-1:0] opq_wa, lit_wa, lit_ra;
    logic [gsl_pkg::STACK_AW-1:0] stk_ra;
    logic [gsl_pkg::SP_W-1:0] sp_m1;
    gsl_pkg::t_frame stk_wd, stk_rd;
    gsl_pkg::t_gpos in_pos, g_q, g_cell;
    gsl_pkg::t_coord q_x, q_y, x_n, y_n, q_div;
    gsl_pkg::t_op m_a, m_b, m_c, m_d;
    logic [gsl_pkg::DW-1:0] d_trial;
    logic d_ge, c_gt, c_ge, c_lt, c3_lit, at_edge, stk_full;

    assign in_acc = i_in_valid && o_in_ready;
    assign blk = r_off | opq_rd;
    assign x_n = r_x + K1;
    assign y_n = r_y - K1;
    assign c_gt = r_pl > r_pr;
    assign c_ge = r_pl >= r_pr;
    assign c_lt = r_pl < r_pr;
    assign at_edge = !r_unl && (r_x == gsl_pkg::t_coord'(r_range));
    assign c3_lit = r_op || ((r_y != r_top || r_ctop) && (r_y != r_bot || c_lt));
    assign stk_full = r_sp == gsl_pkg::SP_W'(gsl_pkg::STACK_DEPTH);
    assign sp_m1 = r_sp - gsl_pkg::SP_W'(1);
    assign stk_ra = sp_m1[gsl_pkg::STACK_AW-1:0];
    assign d_trial = {r_rem[gsl_pkg::DW-2:0], r_num[gsl_pkg::DW-1]};
    assign d_ge = d_trial >= r_den;
    assign q_div = gsl_pkg::t_coord'(r_num[gsl_pkg::CW-1:0]);

    assign in_pos = gsl_pkg::grid_addr(gsl_pkg::t_coord'(i_cell_x),
                                       gsl_pkg::t_coord'(i_cell_y));
    assign g_q = gsl_pkg::to_grid(r_oct, r_org_x, r_org_y, q_x, q_y);
    assign g_cell = gsl_pkg::to_grid(r_oct, r_org_x, r_org_y, r_x, r_y);
    assign lit_ra = in_pos.addr;

    always_comb begin
        q_x = r_x;
        q_y = r_y;
        unique case (r_state)
            S_TB0: q_y = r_top;
            S_TB1: begin
                q_x = blk ? r_x : x_n;
                q_y = r_top + K1;
            end
            S_BB0: q_y = r_bot;
            S_BB1: q_y = r_bot + K1;
            S_C3: begin
                q_x = r_op ? r_x : x_n;
                q_y = r_y + K1;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_a = O0;
        m_b = O0;
        m_c = O0;
        m_d = O0;
        unique case (r_state)
            S_IDLE: begin
                m_a = gsl_pkg::t_op'(i_radius) + O1;
                m_b = gsl_pkg::t_op'(i_radius) + O1;
            end
            S_COL: begin
                m_a = (gsl_pkg::t_op'(r_x) <<< 1) - O1;
                m_b = gsl_pkg::t_op'(r_ty);
            end
            S_BOT: begin
                m_a = (gsl_pkg::t_op'(r_x) <<< 1) - O1;
                m_b = gsl_pkg::t_op'(r_by);
            end
            S_TB0: begin
                m_a = gsl_pkg::t_op'(r_ty);
                m_b = gsl_pkg::t_op'(r_x) <<< 1;
                m_c = gsl_pkg::t_op'(r_tx);
                m_d = (gsl_pkg::t_op'(r_top) <<< 1) + O1;
            end
            S_TB4: begin
                m_a = gsl_pkg::t_op'(r_ty);
                m_b = gsl_pkg::t_op'(r_ax);
                m_c = gsl_pkg::t_op'(r_tx);
                m_d = (gsl_pkg::t_op'(r_top) <<< 1) + O1;
            end
            S_BB0: begin
                m_a = gsl_pkg::t_op'(r_by);
                m_b = gsl_pkg::t_op'(r_x) <<< 1;
                m_c = gsl_pkg::t_op'(r_bx);
                m_d = (gsl_pkg::t_op'(r_bot) <<< 1) + O1;
            end
            S_C0: begin
                m_a = gsl_pkg::t_op'(r_x);
                m_b = gsl_pkg::t_op'(r_x);
                m_c = gsl_pkg::t_op'(r_y);
                m_d = gsl_pkg::t_op'(r_y);
            end
            S_C1: begin
                m_a = gsl_pkg::t_op'(r_ty);
                m_b = (gsl_pkg::t_op'(r_x) <<< 2) + O1;
                m_c = gsl_pkg::t_op'(r_tx);
                m_d = (gsl_pkg::t_op'(r_y) <<< 2) - O1;
            end
            S_C2: begin
                m_a = gsl_pkg::t_op'(r_by);
                m_b = (gsl_pkg::t_op'(r_x) <<< 2) - O1;
                m_c = gsl_pkg::t_op'(r_bx);
                m_d = (gsl_pkg::t_op'(r_y) <<< 2) + O1;
            end
            S_OPN1: begin
                m_a = gsl_pkg::t_op'(r_ty);
                m_b = gsl_pkg::t_op'(r_nx);
                m_c = gsl_pkg::t_op'(r_tx);
                m_d = gsl_pkg::t_op'(r_ny);
            end
            S_TRN1: begin
                m_a = gsl_pkg::t_op'(r_by);
                m_b = gsl_pkg::t_op'(r_nx);
                m_c = gsl_pkg::t_op'(r_bx);
                m_d = gsl_pkg::t_op'(r_ny);
            end
            default: ;
        endcase
    end

    always_comb begin
        opq_we = 1'b0;
        opq_wa = in_pos.addr;
        opq_wd = (i_tile_kind == gsl_pkg::TILE_WALL) ||
                 (i_tile_kind == gsl_pkg::TILE_DOOR_CLOSED);
        lit_we = 1'b0;
        lit_wa = g_cell.addr;
        lit_wd = 1'b1;
        unique case (r_state)
            S_RST_CLR: begin
                opq_we = 1'b1;
                opq_wa = r_clr;
                opq_wd = 1'b0;
                lit_we = 1'b1;
                lit_wa = r_clr;
                lit_wd = 1'b0;
            end
            S_CLR: begin
                lit_we = 1'b1;
                lit_wa = r_clr;
                lit_wd = 1'b0;
            end
            S_IDLE: begin
                opq_we = in_acc && (i_mode == gsl_pkg::MODE_LOAD) && !in_pos.off;
                lit_we = in_acc && (i_mode == gsl_pkg::MODE_SHINE) && !in_pos.off;
                lit_wa = in_pos.addr;
            end
            S_C3: lit_we = c3_lit && !g_cell.off;
            default: ;
        endcase
    end

    assign stk_we = (r_state == S_OPN2) && c_gt && (r_y != r_bot) && !stk_full;
    assign stk_wd = '{x: x_n[gsl_pkg::FR_FW-1:0], ty: r_ty[gsl_pkg::FR_FW-1:0],
                      tx: r_tx[gsl_pkg::FR_FW-1:0], by: r_ny[gsl_pkg::FR_FW-1:0],
                      bx: r_nx[gsl_pkg::FR_FW-1:0]};

    gsl_ram #(.WIDTH(1), .DEPTH(gsl_pkg::MAP_CELLS)) u_opq_ram (
        .i_clk   (i_clk),
        .i_we    (opq_we),
        .i_waddr (opq_wa),
        .i_wdata (opq_wd),
        .i_raddr (g_q.addr),
        .o_rdata (opq_rd)
    );

    gsl_ram #(.WIDTH(1), .DEPTH(gsl_pkg::MAP_CELLS)) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (lit_we),
        .i_waddr (lit_wa),
        .i_wdata (lit_wd),
        .i_raddr (lit_ra),
        .o_rdata (lit_rd)
    );

    gsl_ram #(.WIDTH(gsl_pkg::FRAME_W), .DEPTH(gsl_pkg::STACK_DEPTH)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp[gsl_pkg::STACK_AW-1:0]),
        .i_wdata (stk_wd),
        .i_raddr (stk_ra),
        .o_rdata (stk_rd)
    );

    always_ff @(posedge i_clk) begin
        r_pl <= m_a * m_b;
        r_pr <= m_c * m_d;
        r_off <= g_q.off;
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_sp <= '0;
            r_oct <= '0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_RST_CLR, S_CLR: begin
                    r_clr <= r_clr + gsl_pkg::MAP_AW'(1);
                    if (r_clr == gsl_pkg::MAP_AW'(gsl_pkg::MAP_CELLS - 1)) begin
                        r_ovalid <= (r_state == S_CLR);
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_lit <= 1'b0;
                        r_ovf <= 1'b0;
                        r_in_off <= in_pos.off;
                        r_clr <= '0;
                        r_range <= i_radius;
                        r_unl <= i_radius[gsl_pkg::RAD_W-1];
                        r_org_x <= gsl_pkg::t_coord'(i_cell_x);
                        r_org_y <= gsl_pkg::t_coord'(i_cell_y);
                        unique case (i_mode)
                            gsl_pkg::MODE_LOAD: r_ovalid <= 1'b1;
                            gsl_pkg::MODE_SHINE: r_state <= S_SH0;
                            gsl_pkg::MODE_CLEAR: r_state <= S_CLR;
                            gsl_pkg::MODE_READ: r_state <= S_RD;
                        endcase
                    end
                end
                S_RD: begin
                    r_lit <= !r_in_off && lit_rd;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SH0: begin
                    r_reach2 <= r_pl;
                    r_oct <= '0;
                    r_sp <= '0;
                    r_x <= K1;
                    r_ty <= K1;
                    r_tx <= K1;
                    r_by <= K0;
                    r_bx <= K1;
                    r_state <= S_COL;
                end
                S_COL: begin
                    if (!r_unl && (r_x > gsl_pkg::t_coord'(r_range))) begin
                        r_state <= S_POP;
                    end else if (r_tx == K1) begin
                        r_top <= r_x;
                        r_state <= S_BOT;
                    end else begin
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV, S_BDIV: begin
                    r_num <= gsl_pkg::DW'(r_pl + gsl_pkg::t_prod'(
                                (r_state == S_TDIV) ? r_tx : r_bx));
                    r_den <= gsl_pkg::DW'({(r_state == S_TDIV) ? r_tx : r_bx, 1'b0});
                    r_rem <= '0;
                    r_dcnt <= '0;
                    r_dbot <= (r_state == S_BDIV);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= d_ge ? d_trial - r_den : d_trial;
                    r_num <= {r_num[gsl_pkg::DW-2:0], d_ge};
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(gsl_pkg::DW - 1)) begin
                        r_state <= r_dbot ? S_BQ : S_TQ;
                    end
                end
                S_TQ: begin
                    r_top <= q_div;
                    r_state <= S_TB0;
                end
                S_TB0: r_state <= S_TB1;
                S_TB1: begin
                    if (blk) begin
                        r_state <= c_ge ? S_TB2 : S_BOT;
                    end else begin
                        r_state <= S_TB3;
                    end
                end
                S_TB2: begin
                    if (!blk) begin
                        r_top <= r_top + K1;
                    end
                    r_state <= S_BOT;
                end
                S_TB3: begin
                    r_ax <= (r_x <<< 1) + gsl_pkg::t_coord'(blk);
                    r_state <= S_TB4;
                end
                S_TB4: r_state <= S_TB5;
                S_TB5: begin
                    if (c_gt) begin
                        r_top <= r_top + K1;
                    end
                    r_state <= S_BOT;
                end
                S_BOT: begin
                    if (r_by == K0) begin
                        r_bot <= K0;
                        r_state <= S_CINIT;
                    end else begin
                        r_state <= S_BDIV;
                    end
                end
                S_BQ: begin
                    r_bot <= q_div;
                    r_state <= S_BB0;
                end
                S_BB0: r_state <= S_BB1;
                S_BB1: r_state <= (c_ge && blk) ? S_BB2 : S_CINIT;
                S_BB2: begin
                    if (!blk) begin
                        r_bot <= r_bot + K1;
                    end
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    r_y <= r_top;
                    r_was <= WAS_NONE;
                    r_state <= S_C0;
                end
                S_C0: r_state <= (r_y < r_bot) ? S_CEND : S_C1;
                S_C1: begin
                    if (!r_unl && (r_pl + r_pr >= r_reach2)) begin
                        r_y <= y_n;
                        r_state <= S_C0;
                    end else begin
                        r_op <= blk;
                        r_state <= S_C2;
                    end
                end
                S_C2: begin
                    r_ctop <= c_gt;
                    r_state <= S_C3;
                end
                S_C3: begin
                    if (at_edge) begin
                        r_y <= y_n;
                        r_state <= S_C0;
                    end else if (r_op) begin
                        if (r_was == WAS_OPEN) begin
                            r_state <= S_OPN0;
                        end else begin
                            r_was <= WAS_OPAQ;
                            r_y <= y_n;
                            r_state <= S_C0;
                        end
                    end else begin
                        if (r_was == WAS_OPAQ) begin
                            r_state <= S_TRN0;
                        end else begin
                            r_was <= WAS_OPEN;
                            r_y <= y_n;
                            r_state <= S_C0;
                        end
                    end
                end
                S_OPN0, S_TRN0: begin
                    r_nx <= (r_state == S_OPN0) ? (r_x <<< 1) - gsl_pkg::t_coord'(blk)
                                                : (r_x <<< 1) + gsl_pkg::t_coord'(blk);
                    r_ny <= (r_y <<< 1) + K1;
                    r_state <= (r_state == S_OPN0) ? S_OPN1 : S_TRN1;
                end
                S_OPN1: r_state <= S_OPN2;
                S_TRN1: r_state <= S_TRN2;
                S_OPN2: begin
                    if (c_gt && (r_y == r_bot)) begin
                        r_by <= r_ny;
                        r_bx <= r_nx;
                        r_state <= S_CEND;
                    end else if (!c_gt && (r_y == r_bot)) begin
                        r_state <= S_POP;
                    end else begin
                        if (c_gt) begin
                            if (stk_full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_sp <= r_sp + gsl_pkg::SP_W'(1);
                            end
                        end
                        r_was <= WAS_OPAQ;
                        r_y <= y_n;
                        r_state <= S_C0;
                    end
                end
                S_TRN2: begin
                    if (c_ge) begin
                        r_state <= S_POP;
                    end else begin
                        r_ty <= r_ny;
                        r_tx <= r_nx;
                        r_was <= WAS_OPEN;
                        r_y <= y_n;
                        r_state <= S_C0;
                    end
                end
                S_CEND: begin
                    if (r_was != WAS_OPEN) begin
                        r_state <= S_POP;
                    end else begin
                        r_x <= x_n;
                        r_state <= S_COL;
                    end
                end
                S_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= sp_m1;
                        r_state <= S_POPW;
                    end else if (r_oct == 3'd7) begin
                        r_state <= S_DONE;
                    end else begin
                        r_oct <= r_oct + 3'd1;
                        r_x <= K1;
                        r_ty <= K1;
                        r_tx <= K1;
                        r_by <= K0;
                        r_bx <= K1;
                        r_state <= S_COL;
                    end
                end
                S_POPW: begin
                    r_x <= gsl_pkg::t_coord'(stk_rd.x);
                    r_ty <= gsl_pkg::t_coord'(stk_rd.ty);
                    r_tx <= gsl_pkg::t_coord'(stk_rd.tx);
                    r_by <= gsl_pkg::t_coord'(stk_rd.by);
                    r_bx <= gsl_pkg::t_coord'(stk_rd.bx);
                    r_state <= S_COL;
                end
                S_DONE: begin
                    r_oct <= '0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_lit_bit = r_lit;
    assign o_stack_overflow = r_ovf;

    a_ready_blocks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("Input ready while a result is pending.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("Ready stayed high after a transaction was accepted.");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= gsl_pkg::SP_W'(gsl_pkg::STACK_DEPTH))
        else $error("Frame stack count exceeded its depth.");

    a_ovf_only_shine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stack_overflow) |-> !o_lit_bit)
        else $error("Overflow flag raised on a lit read result.");

endmodule
